@@ sv/vshp_pkg.sv @@
// ----------------------------------------------------------------------------
// vshp_pkg
// Types, start codes and frame rate tables shared by the sequence header
// parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package vshp_pkg;

    // bytes of a unit that the parser ever looks at
    localparam int HDR_BYTES = 12;

    // unit lengths that gate the decode
    localparam int MIN_UNIT_LEN = 4;
    localparam int EXT_UNIT_LEN = 10;
    localparam int SEQ_UNIT_LEN = 12;

    // start code bytes
    localparam logic [7:0] SC_PREFIX_0  = 8'h00;
    localparam logic [7:0] SC_PREFIX_1  = 8'h00;
    localparam logic [7:0] SC_PREFIX_2  = 8'h01;
    localparam logic [7:0] SC_SEQ_HDR   = 8'hB3;
    localparam logic [7:0] SC_EXTENSION = 8'hB5;

    // frame rate tables, indexed by frame_rate_code
    localparam logic [15:0] RATE_NUM_TAB [16] = '{
        16'd0, 16'd24000, 16'd24, 16'd25, 16'd30000, 16'd30, 16'd50, 16'd60000,
        16'd60, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0
    };
    localparam logic [9:0] RATE_DIV_TAB [16] = '{
        10'd1, 10'd1001, 10'd1, 10'd1, 10'd1001, 10'd1, 10'd1, 10'd1001,
        10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1
    };

    typedef logic [HDR_BYTES-1:0][7:0] t_unit_bytes;

    // unit view handed from capture to decode
    typedef struct packed {
        logic        fire;    // last beat of a unit is being processed
        logic        ge_min;  // at least four bytes
        logic        ge_ext;  // long enough for an extension
        logic        ge_seq;  // long enough for a sequence header
        t_unit_bytes bytes;   // captured bytes, current beat merged in
    } t_unit_view;

    // fields latched from a sequence header
    typedef struct packed {
        logic [11:0] hsize;
        logic [11:0] vsize;
        logic [3:0]  aspect;
        logic [3:0]  rate_code;
        logic [17:0] bit_rate;
        logic [9:0]  vbv;
    } t_hdr;

    // committed attributes
    typedef struct packed {
        logic [13:0] horiz_size;
        logic [13:0] vert_size;
        logic [3:0]  aspect_code;
        logic [17:0] rate_numerator;
        logic [14:0] rate_divisor;
        logic        is_progressive;
        logic        is_interlaced;
        logic [1:0]  chroma_sampling;
        logic [29:0] bit_rate;
        logic [17:0] buffer_size;
    } t_attrs;

endpackage

`default_nettype wire

@@ sv/vshp_capture.sv @@
// ----------------------------------------------------------------------------
// vshp_capture
// Input register, byte counter and capture of the first bytes of a unit.
// ----------------------------------------------------------------------------
`default_nettype none

module vshp_capture #(
    parameter int CAPTURE_LEN = 12
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [7:0]            i_byte_value,
    input  wire logic                  i_unit_first,
    input  wire logic                  i_unit_last,
    input  wire logic                  i_res_busy,
    output vshp_pkg::t_unit_view       o_view
);
    import vshp_pkg::*;

    localparam int CW = $clog2(CAPTURE_LEN + 1);

    logic          r_vld;
    logic [7:0]    r_byte;
    logic          r_first;
    logic          r_last;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] n_idx;
    logic [7:0]    r_cap [HDR_BYTES];
    logic [CW-1:0] w_base;
    logic [CW-1:0] w_count;
    logic          w_proc;

    // beat in the input register moves on unless it needs a busy result slot
    assign w_proc  = r_vld && !(r_last && i_res_busy);
    assign o_stall = r_vld && !w_proc;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (!o_stall) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_byte  <= i_byte_value;
            r_first <= i_unit_first;
            r_last  <= i_unit_last;
        end
    end

    // byte position of this beat and the unit length after it, saturating
    assign w_base  = r_first ? '0 : r_idx;
    assign w_count = (w_base < CW'(CAPTURE_LEN)) ? w_base + CW'(1) : w_base;

    always_comb begin
        n_idx = r_idx;
        if (w_proc) begin
            n_idx = r_last ? '0 : w_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

    // capture store, one fixed slot per byte position
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < HDR_BYTES; k++) begin
            if (w_proc && w_base == CW'(k)) begin
                r_cap[k] <= r_byte;
            end
        end
    end

    // unit view with the current beat merged in
    always_comb begin
        o_view.fire   = w_proc && r_last;
        o_view.ge_min = w_count >= CW'(MIN_UNIT_LEN);
        o_view.ge_ext = w_count >= CW'(EXT_UNIT_LEN);
        o_view.ge_seq = w_count >= CW'(SEQ_UNIT_LEN);
        for (int k = 0; k < HDR_BYTES; k++) begin
            o_view.bytes[k] = (w_base == CW'(k)) ? r_byte : r_cap[k];
        end
    end

    // a beat that is stalled stays in the input register
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> r_vld)
        else $error("stalled beat left the input register");

    // the counter never runs past the capture length
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= CW'(CAPTURE_LEN))
        else $error("byte counter beyond capture length");

    // the counter restarts after the last beat of a unit
    a_idx_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && r_last) |=> r_idx == '0)
        else $error("byte counter not cleared after unit end");

endmodule

`default_nettype wire

@@ sv/vshp_decode.sv @@
// ----------------------------------------------------------------------------
// vshp_decode
// Start code check, sequence header latch, extension merge, commit and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module vshp_decode (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire vshp_pkg::t_unit_view  i_view,
    input  wire logic                  i_stall,
    output logic                       o_res_busy,
    output logic                       o_valid,
    output logic                       o_changed,
    output vshp_pkg::t_attrs           o_attrs
);
    import vshp_pkg::*;

    logic        r_wait;
    logic        r_attrs_valid;
    t_hdr        r_hdr;
    t_attrs      r_committed;
    logic        r_out_valid;
    logic        r_changed;

    logic        w_sc_ok;
    logic        w_is_seq;
    logic        w_is_ext;
    logic        w_commit;
    t_hdr        w_hdr;
    t_attrs      w_attrs;
    logic [2:0]  w_num_scale;
    logic [5:0]  w_div_scale;
    logic [15:0] w_tab_num;
    logic [9:0]  w_tab_div;
    logic [31:0] w_f;
    t_unit_bytes d;

    assign d = i_view.bytes;

    // unit classification
    assign w_sc_ok  = i_view.ge_min && d[0] == SC_PREFIX_0 && d[1] == SC_PREFIX_1
                      && d[2] == SC_PREFIX_2;
    assign w_is_seq = w_sc_ok && d[3] == SC_SEQ_HDR && i_view.ge_seq;
    assign w_is_ext = d[3] == SC_EXTENSION && i_view.ge_ext;
    assign w_commit = w_sc_ok && !w_is_seq && r_wait;

    // sequence header fields
    assign w_f = {d[8], d[9], d[10], d[11]};
    always_comb begin
        w_hdr.hsize     = {d[4], d[5][7:4]};
        w_hdr.vsize     = {d[5][3:0], d[6]};
        w_hdr.aspect    = d[7][7:4];
        w_hdr.rate_code = d[7][3:0];
        w_hdr.bit_rate  = w_f[31:14];
        w_hdr.vbv       = w_f[12:3];
    end

    // frame rate from the latched code, scaled by the extension
    assign w_tab_num   = RATE_NUM_TAB[r_hdr.rate_code];
    assign w_tab_div   = RATE_DIV_TAB[r_hdr.rate_code];
    assign w_num_scale = {1'b0, d[9][6:5]} + 3'd1;
    assign w_div_scale = {1'b0, d[9][4:0]} + 6'd1;

    // attributes to commit, MPEG-2 merge or plain MPEG-1
    always_comb begin
        w_attrs.aspect_code = r_hdr.aspect;
        if (w_is_ext) begin
            w_attrs.is_progressive  = d[5][3];
            w_attrs.is_interlaced   = !d[5][3];
            w_attrs.chroma_sampling = d[5][2:1];
            w_attrs.horiz_size      = {d[5][0], d[6][7], r_hdr.hsize};
            w_attrs.vert_size       = {d[6][6:5], r_hdr.vsize};
            w_attrs.rate_numerator  = 18'(w_tab_num) * 18'(w_num_scale);
            w_attrs.rate_divisor    = 15'(w_tab_div) * 15'(w_div_scale);
            w_attrs.bit_rate        = {d[6][4:0], d[7][7:1], r_hdr.bit_rate};
            w_attrs.buffer_size     = {d[8], r_hdr.vbv};
        end else begin
            w_attrs.is_progressive  = 1'b0;
            w_attrs.is_interlaced   = 1'b0;
            w_attrs.chroma_sampling = 2'd0;
            w_attrs.horiz_size      = {2'd0, r_hdr.hsize};
            w_attrs.vert_size       = {2'd0, r_hdr.vsize};
            w_attrs.rate_numerator  = {2'd0, w_tab_num};
            w_attrs.rate_divisor    = {5'd0, w_tab_div};
            w_attrs.bit_rate        = {12'd0, r_hdr.bit_rate};
            w_attrs.buffer_size     = {8'd0, r_hdr.vbv};
        end
    end

    // header latch, wait flag and committed attributes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr         <= '0;
            r_wait        <= 1'b0;
            r_attrs_valid <= 1'b0;
            r_committed   <= '0;
        end else if (i_view.fire) begin
            if (w_is_seq) begin
                r_hdr  <= w_hdr;
                r_wait <= 1'b1;
            end else if (w_commit) begin
                r_wait        <= 1'b0;
                r_attrs_valid <= 1'b1;
                r_committed   <= w_attrs;
            end
        end
    end

    // result register; the attributes come straight from the committed set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_changed   <= 1'b0;
        end else begin
            if (i_view.fire) begin
                r_out_valid <= 1'b1;
                r_changed   <= w_commit && (!r_attrs_valid || w_attrs != r_committed);
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res_busy = r_out_valid && i_stall;
    assign o_valid    = r_out_valid;
    assign o_changed  = r_changed;
    assign o_attrs    = r_committed;

    // every unit end yields a result beat
    a_fire_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_view.fire |=> r_out_valid)
        else $error("unit end without result");

    // a commit clears the wait flag
    a_commit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_view.fire && w_commit) |=> !r_wait)
        else $error("wait flag still set after commit");

    // the first commit is always reported as a change
    a_first_changed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_attrs_valid) |-> r_changed)
        else $error("first commit not flagged as changed");

    // before any commit the attributes keep their reset value
    a_reset_attrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_attrs_valid |-> r_committed == '0)
        else $error("attributes changed without commit");

endmodule

`default_nettype wire

@@ sv/video_sequence_header_parser_unit.sv @@
// ----------------------------------------------------------------------------
// video_sequence_header_parser_unit
// Parses video units byte by byte, latches sequence header attributes and
// reports the committed attributes at the end of every unit.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+----------------------------------
//   bytes    | in        | i_valid / o_stall  | byte_value, unit_first, unit_last
//   results  | out       | o_valid / i_stall  | changed and committed attributes
//
// One beat per cycle is taken unless o_stall holds it; a beat is registered in
// the input register, and the result of a unit end beat then goes to the result register.
// For the unit end beat, capture merge, decode and commit are combinational
// between the input register and the result register.
// Synchronous active-low reset clears the counter, flags and attributes.
// A stalled result holds only unit end beats; other beats keep flowing.
// ----------------------------------------------------------------------------
`default_nettype none

module video_sequence_header_parser_unit #(
    parameter int CAPTURE_LEN = 12
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_byte_value,
    input  wire logic        i_unit_first,
    input  wire logic        i_unit_last,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_changed,
    output logic [13:0]      o_horiz_size,
    output logic [13:0]      o_vert_size,
    output logic [3:0]       o_aspect_code,
    output logic [17:0]      o_rate_numerator,
    output logic [14:0]      o_rate_divisor,
    output logic             o_is_progressive,
    output logic             o_is_interlaced,
    output logic [1:0]       o_chroma_sampling,
    output logic [29:0]      o_bit_rate,
    output logic [17:0]      o_buffer_size
);
    import vshp_pkg::*;

    t_unit_view w_view;
    t_attrs     w_attrs;
    logic       w_res_busy;

    // byte capture and counting
    vshp_capture #(
        .CAPTURE_LEN (CAPTURE_LEN)
    ) u_capture (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_byte_value (i_byte_value),
        .i_unit_first (i_unit_first),
        .i_unit_last  (i_unit_last),
        .i_res_busy   (w_res_busy),
        .o_view       (w_view)
    );

    // unit decode and result
    vshp_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_view     (w_view),
        .i_stall    (i_stall),
        .o_res_busy (w_res_busy),
        .o_valid    (o_valid),
        .o_changed  (o_changed),
        .o_attrs    (w_attrs)
    );

    // result fields
    assign o_horiz_size      = w_attrs.horiz_size;
    assign o_vert_size       = w_attrs.vert_size;
    assign o_aspect_code     = w_attrs.aspect_code;
    assign o_rate_numerator  = w_attrs.rate_numerator;
    assign o_rate_divisor    = w_attrs.rate_divisor;
    assign o_is_progressive  = w_attrs.is_progressive;
    assign o_is_interlaced   = w_attrs.is_interlaced;
    assign o_chroma_sampling = w_attrs.chroma_sampling;
    assign o_bit_rate        = w_attrs.bit_rate;
    assign o_buffer_size     = w_attrs.buffer_size;

endmodule

`default_nettype wire

@@ tb/sv/video_sequence_header_parser_unit_test.sv @@
// ----------------------------------------------------------------------------
// video_sequence_header_parser_unit_test
// Drives video units byte by byte into the sequence header parser with random
// gaps and result stalls, predicts the committed attributes of every unit and
// checks each result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module video_sequence_header_parser_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import vshp_pkg::*;

    localparam int TARGET_BEATS = 1350;
    localparam int CYCLE_LIMIT  = 600000;

    // frame rate codes with a defined rate
    localparam logic [3:0] FR_23_976 = 4'd1;
    localparam logic [3:0] FR_24     = 4'd2;
    localparam logic [3:0] FR_25     = 4'd3;
    localparam logic [3:0] FR_29_97  = 4'd4;
    localparam logic [3:0] FR_30     = 4'd5;
    localparam logic [3:0] FR_50     = 4'd6;
    localparam logic [3:0] FR_59_94  = 4'd7;
    localparam logic [3:0] FR_60     = 4'd8;

    typedef struct {
        logic   changed;
        t_attrs attrs;
    } t_unit_report;

    // ------------------------------------------------------------------
    // attribute tracker: mirrors the parser state, holds expected reports
    // ------------------------------------------------------------------
    class seq_attr_tracker;
        int           byte_count;
        logic [7:0]   unit_bytes [HDR_BYTES];
        t_hdr         seq_hdr;
        bit           awaiting_commit;
        bit           attrs_known;
        t_attrs       current;
        t_unit_report pending_reports [$];
        int           mismatches;

        function new();
            byte_count      = 0;
            foreach (unit_bytes[i]) unit_bytes[i] = 8'h00;
            seq_hdr         = '0;
            awaiting_commit = 1'b0;
            attrs_known     = 1'b0;
            current         = '0;
            mismatches      = 0;
        endfunction

        function int pending();
            return pending_reports.size();
        endfunction

        // table rate for a frame rate code
        function automatic void table_rate(input logic [3:0] code, output int num,
                                           output int div);
            case (code)
                FR_23_976: begin num = 24000; div = 1001; end
                FR_24:     begin num = 24;    div = 1;    end
                FR_25:     begin num = 25;    div = 1;    end
                FR_29_97:  begin num = 30000; div = 1001; end
                FR_30:     begin num = 30;    div = 1;    end
                FR_50:     begin num = 50;    div = 1;    end
                FR_59_94:  begin num = 60000; div = 1001; end
                FR_60:     begin num = 60;    div = 1;    end
                default:   begin num = 0;     div = 1;    end
            endcase
        endfunction

        // decode a finished unit, returns the changed flag
        function automatic bit decode_unit(int count);
            t_attrs     next;
            int         num;
            int         div;
            int         n_scale;
            int         d_scale;
            logic [31:0] word;
            next = '0;
            if (count < MIN_UNIT_LEN || unit_bytes[0] != SC_PREFIX_0 ||
                unit_bytes[1] != SC_PREFIX_1 || unit_bytes[2] != SC_PREFIX_2)
                return 1'b0;

            // sequence header: latch and wait for the next unit
            if (unit_bytes[3] == SC_SEQ_HDR && count >= SEQ_UNIT_LEN) begin
                word = {unit_bytes[8], unit_bytes[9], unit_bytes[10], unit_bytes[11]};
                seq_hdr.hsize     = {unit_bytes[4], unit_bytes[5][7:4]};
                seq_hdr.vsize     = {unit_bytes[5][3:0], unit_bytes[6]};
                seq_hdr.aspect    = unit_bytes[7][7:4];
                seq_hdr.rate_code = unit_bytes[7][3:0];
                seq_hdr.bit_rate  = word[31:14];
                seq_hdr.vbv       = word[12:3];
                awaiting_commit   = 1'b1;
                return 1'b0;
            end

            if (!awaiting_commit)
                return 1'b0;

            table_rate(seq_hdr.rate_code, num, div);
            next.aspect_code = seq_hdr.aspect;
            if (unit_bytes[3] == SC_EXTENSION && count >= EXT_UNIT_LEN) begin
                // mpeg-2 sequence extension
                n_scale = int'(unit_bytes[9][6:5]) + 1;
                d_scale = int'(unit_bytes[9][4:0]) + 1;
                next.is_progressive  = unit_bytes[5][3];
                next.is_interlaced   = ~unit_bytes[5][3];
                next.chroma_sampling = unit_bytes[5][2:1];
                next.horiz_size      = {unit_bytes[5][0], unit_bytes[6][7], seq_hdr.hsize};
                next.vert_size       = {unit_bytes[6][6:5], seq_hdr.vsize};
                next.rate_numerator  = 18'(num * n_scale);
                next.rate_divisor    = 15'(div * d_scale);
                next.bit_rate        = {unit_bytes[6][4:0], unit_bytes[7][7:1],
                                        seq_hdr.bit_rate};
                next.buffer_size     = {unit_bytes[8], seq_hdr.vbv};
            end else begin
                // plain mpeg-1 values
                next.horiz_size     = {2'b00, seq_hdr.hsize};
                next.vert_size      = {2'b00, seq_hdr.vsize};
                next.rate_numerator = 18'(num);
                next.rate_divisor   = 15'(div);
                next.bit_rate       = {12'd0, seq_hdr.bit_rate};
                next.buffer_size    = {8'd0, seq_hdr.vbv};
            end
            decode_unit     = !attrs_known || (next != current);
            current         = next;
            awaiting_commit = 1'b0;
            attrs_known     = 1'b1;
        endfunction

        // note one accepted input beat
        function void note_beat(logic [7:0] value, logic first, logic last);
            t_unit_report rep;
            if (first)
                byte_count = 0;
            if (byte_count < HDR_BYTES) begin
                unit_bytes[byte_count] = value;
                byte_count++;
            end
            if (last) begin
                rep.changed = decode_unit(byte_count);
                rep.attrs   = current;
                byte_count  = 0;
                pending_reports.push_back(rep);
            end
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task compare_field(string name, longint unsigned got, longint unsigned want);
            if (got != want)
                report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        endtask

        // check one accepted result beat
        task check_report(logic changed, t_attrs got);
            t_unit_report want;
            if (pending_reports.size() == 0) begin
                report_mismatch("result beat with no unit end pending");
            end else begin
                want = pending_reports.pop_front();
                compare_field("changed", changed, want.changed);
                compare_field("horiz_size", got.horiz_size, want.attrs.horiz_size);
                compare_field("vert_size", got.vert_size, want.attrs.vert_size);
                compare_field("aspect_code", got.aspect_code, want.attrs.aspect_code);
                compare_field("rate_numerator", got.rate_numerator,
                              want.attrs.rate_numerator);
                compare_field("rate_divisor", got.rate_divisor, want.attrs.rate_divisor);
                compare_field("is_progressive", got.is_progressive,
                              want.attrs.is_progressive);
                compare_field("is_interlaced", got.is_interlaced,
                              want.attrs.is_interlaced);
                compare_field("chroma_sampling", got.chroma_sampling,
                              want.attrs.chroma_sampling);
                compare_field("bit_rate", got.bit_rate, want.attrs.bit_rate);
                compare_field("buffer_size", got.buffer_size, want.attrs.buffer_size);
            end
        endtask
    endclass

    // ------------------------------------------------------------------
    // signals and block under test
    // ------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_byte_value = 8'h00;
    logic        i_unit_first = 1'b0;
    logic        i_unit_last = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_changed;
    logic [13:0] o_horiz_size;
    logic [13:0] o_vert_size;
    logic [3:0]  o_aspect_code;
    logic [17:0] o_rate_numerator;
    logic [14:0] o_rate_divisor;
    logic        o_is_progressive;
    logic        o_is_interlaced;
    logic [1:0]  o_chroma_sampling;
    logic [29:0] o_bit_rate;
    logic [17:0] o_buffer_size;

    video_sequence_header_parser_unit u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_byte_value      (i_byte_value),
        .i_unit_first      (i_unit_first),
        .i_unit_last       (i_unit_last),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_changed         (o_changed),
        .o_horiz_size      (o_horiz_size),
        .o_vert_size       (o_vert_size),
        .o_aspect_code     (o_aspect_code),
        .o_rate_numerator  (o_rate_numerator),
        .o_rate_divisor    (o_rate_divisor),
        .o_is_progressive  (o_is_progressive),
        .o_is_interlaced   (o_is_interlaced),
        .o_chroma_sampling (o_chroma_sampling),
        .o_bit_rate        (o_bit_rate),
        .o_buffer_size     (o_buffer_size)
    );

    seq_attr_tracker tracker = new();

    // clock, 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // run limit
    int cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // result side: check accepted beats, stall at random
    // ------------------------------------------------------------------
    bit     rx_calm = 1'b0;
    int     stall_left = 0;
    int     rx_roll;
    t_attrs got_attrs;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            got_attrs.horiz_size      = o_horiz_size;
            got_attrs.vert_size       = o_vert_size;
            got_attrs.aspect_code     = o_aspect_code;
            got_attrs.rate_numerator  = o_rate_numerator;
            got_attrs.rate_divisor    = o_rate_divisor;
            got_attrs.is_progressive  = o_is_progressive;
            got_attrs.is_interlaced   = o_is_interlaced;
            got_attrs.chroma_sampling = o_chroma_sampling;
            got_attrs.bit_rate        = o_bit_rate;
            got_attrs.buffer_size     = o_buffer_size;
            tracker.check_report(o_changed, got_attrs);
        end
        // stall pattern for the next edge
        if (rx_calm) begin
            i_stall    <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else begin
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 65) begin
                i_stall <= 1'b0;
            end else begin
                i_stall    <= 1'b1;
                stall_left = (rx_roll < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
            end
        end
    end

    // ------------------------------------------------------------------
    // byte side
    // ------------------------------------------------------------------
    bit         tx_calm = 1'b0;
    int         beats_sent = 0;
    logic [7:0] unit_buf [$];
    logic [7:0] saved_hdr [$];
    logic [7:0] saved_follow [$];
    bit         have_saved = 1'b0;

    function automatic int pick_gap();
        int roll;
        if (tx_calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // one beat, waits for acceptance
    task automatic send_beat(logic [7:0] value, logic first, logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_byte_value <= value;
        i_unit_first <= first;
        i_unit_last  <= last;
        do @(posedge i_clk); while (o_stall);
        tracker.note_beat(value, first, last);
        beats_sent++;
    endtask

    // send unit_buf, flags on its first and last byte
    task automatic send_unit(bit with_first, bit with_last);
        int n;
        n = unit_buf.size();
        for (int i = 0; i < n; i++)
            send_beat(unit_buf[i], (i == 0) && with_first, (i == n - 1) && with_last);
    endtask

    // unit with a good start code, random payload, truncated to len bytes
    task automatic build_unit(logic [7:0] code, int len);
        unit_buf = {};
        for (int i = 0; i < len; i++) begin
            case (i)
                0:       unit_buf.push_back(SC_PREFIX_0);
                1:       unit_buf.push_back(SC_PREFIX_1);
                2:       unit_buf.push_back(SC_PREFIX_2);
                3:       unit_buf.push_back(code);
                default: unit_buf.push_back(8'($urandom));
            endcase
        end
    endtask

    function automatic logic [7:0] other_code();
        logic [7:0] c;
        c = 8'($urandom);
        if (c == SC_SEQ_HDR || c == SC_EXTENSION)
            c = 8'h00;
        return c;
    endfunction

    function automatic int header_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return SEQ_UNIT_LEN;
        if (roll < 90)
            return $urandom_range(SEQ_UNIT_LEN + 1, 16);
        return $urandom_range(MIN_UNIT_LEN, SEQ_UNIT_LEN - 1);
    endfunction

    // header followed by a second unit that may commit it
    task automatic header_sequence();
        int roll;
        if (have_saved && $urandom_range(0, 4) == 0) begin
            // same pair again, so a commit can come without change
            unit_buf = saved_hdr;
            send_unit(1'b1, 1'b1);
            unit_buf = saved_follow;
            send_unit(1'b1, 1'b1);
        end else begin
            build_unit(SC_SEQ_HDR, header_len());
            saved_hdr = unit_buf;
            send_unit(1'b1, 1'b1);
            roll = $urandom_range(0, 99);
            if (roll < 50)
                build_unit(SC_EXTENSION, EXT_UNIT_LEN);
            else if (roll < 60)
                build_unit(SC_EXTENSION, $urandom_range(EXT_UNIT_LEN + 1, 16));
            else if (roll < 72)
                build_unit(SC_EXTENSION, $urandom_range(MIN_UNIT_LEN, EXT_UNIT_LEN - 1));
            else if (roll < 90)
                build_unit(other_code(), $urandom_range(MIN_UNIT_LEN, 16));
            else
                build_unit(SC_SEQ_HDR, header_len());
            saved_follow = unit_buf;
            have_saved   = 1'b1;
            send_unit(1'b1, 1'b1);
        end
    endtask

    // broken or unrelated units
    task automatic noise_unit();
        int  roll;
        int  pos;
        roll = $urandom_range(0, 99);
        if (roll < 20) begin
            // too short for a start code
            build_unit(other_code(), $urandom_range(1, MIN_UNIT_LEN - 1));
            send_unit(1'b1, 1'b1);
        end else if (roll < 40) begin
            // damaged start code prefix
            build_unit($urandom_range(0, 1) ? SC_SEQ_HDR : SC_EXTENSION,
                       $urandom_range(MIN_UNIT_LEN, 16));
            pos = $urandom_range(0, 2);
            unit_buf[pos] = unit_buf[pos] ^ (8'h01 << $urandom_range(0, 7));
            send_unit(1'b1, 1'b1);
        end else if (roll < 60) begin
            // unrelated unit, possibly an extension with nothing waiting
            build_unit($urandom_range(0, 1) ? SC_EXTENSION : other_code(),
                       $urandom_range(MIN_UNIT_LEN, 16));
            send_unit(1'b1, 1'b1);
        end else if (roll < 80) begin
            // unit cut off by the next unit_first
            build_unit($urandom_range(0, 1) ? SC_SEQ_HDR : SC_EXTENSION,
                       $urandom_range(1, 14));
            send_unit(1'b1, 1'b0);
        end else begin
            // unit that opens without unit_first
            build_unit($urandom_range(0, 1) ? SC_SEQ_HDR : other_code(),
                       $urandom_range(1, 16));
            send_unit(1'b0, 1'b1);
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // header and extension with every field bit set, invalid rate code
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        build_unit(SC_SEQ_HDR, SEQ_UNIT_LEN);
        for (int i = 4; i < SEQ_UNIT_LEN; i++) unit_buf[i] = 8'hFF;
        send_unit(1'b1, 1'b1);
        build_unit(SC_EXTENSION, EXT_UNIT_LEN);
        for (int i = 4; i < EXT_UNIT_LEN; i++) unit_buf[i] = 8'hFF;
        send_unit(1'b1, 1'b1);
        // single byte unit and a bad prefix
        unit_buf = '{8'h00};
        send_unit(1'b1, 1'b1);
        unit_buf = '{8'h01, 8'h00, 8'h01, SC_SEQ_HDR};
        send_unit(1'b1, 1'b1);

        // random part
        while (beats_sent < TARGET_BEATS) begin
            tx_calm = ($urandom_range(0, 7) == 0);
            rx_calm = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 99) < 65)
                header_sequence();
            else
                noise_unit();
        end
        // close any open unit so the tail is a unit end
        unit_buf = '{8'h00};
        send_unit(1'b0, 1'b1);
        i_valid <= 1'b0;
        tx_calm = 1'b0;
        rx_calm = 1'b0;

        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (tracker.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
